>>> hdl/assert_macros.svh
// Assertion macros used by the RTL files (only the converter top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/hsv_pkg.sv
// Package for the HSV to RGB converter: constants and sector codes.
`default_nettype none
package hsv_pkg;
    localparam int HUE_BITS_DEF = 16;
    localparam int CH_W = 8;
    localparam int PROD_W = 2 * CH_W;
    localparam logic [CH_W-1:0] GRAY_THR_RST = 8'd3;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [8:0] RECIP_255 = 9'd257;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;
endpackage
`default_nettype wire

>>> hdl/hsv_div255.sv
// Registered floor division by 255 of a 16-bit product, by reciprocal multiply.
`default_nettype none
module hsv_div255 (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [hsv_pkg::PROD_W-1:0]   x,
    output logic      [hsv_pkg::CH_W-1:0]     q_reg
);
    import hsv_pkg::*;

    logic [PROD_W:0]       xp1;
    logic [PROD_W+9:0]     prod;
    logic [CH_W-1:0]       q_next;

    // exact for x <= 255*255: ((x + 1) * 257) >> 16
    assign xp1    = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1};
    assign prod   = {{9{1'b0}}, xp1} * {{(PROD_W+1){1'b0}}, RECIP_255};
    assign q_next = prod[PROD_W+CH_W-1:PROD_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule
`default_nettype wire

>>> hdl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter, five-stage pipeline.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------
//  s_       | in        | tdata: hue, saturation, brightness
//  m_       | out       | tdata: red, green, blue
//  cfg_     | in        | gray threshold write, no read-back
//
// One pixel per cycle sustained while m_tready is high; there is one register stage
// per step (input/hue*6, S*F products, V*(255D-S*F), divide by 255, sector select).
// Reset clears all stage valid bits and loads a gray threshold of 3.
// A stage holds only when it is full and the next stage holds; empty stages
// keep filling, so s_tready drops only when all five stages are full.
`default_nettype none
`include "assert_macros.svh"
module hsv_to_rgb_converter #(
    parameter int HUE_BITS = hsv_pkg::HUE_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // hue [HUE_BITS-1:0], saturation [+8], brightness [+8], zero pad
    input  wire logic [((HUE_BITS+2*hsv_pkg::CH_W+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [3*hsv_pkg::CH_W-1:0]    m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [hsv_pkg::CH_W-1:0] cfg_wdata
);
    import hsv_pkg::*;

    localparam int HB   = HUE_BITS;
    localparam int H6_W = HB + 3;
    localparam int SF_W = HB + CH_W;
    localparam int NUM_STAGES = 5;

    logic [CH_W-1:0]            thr_reg;
    logic [NUM_STAGES:1]        vld_reg;
    logic [NUM_STAGES:1]        en;
    logic [NUM_STAGES:0]        vld_in;

    // stage 1
    logic [HB-1:0]              hue_in;
    logic [CH_W-1:0]            sat_in, val_in;
    logic [H6_W-1:0]            h6_next, h6_reg;
    logic [CH_W-1:0]            s1_reg, v1_reg;
    logic                       grey1_next, grey1_reg;

    // stage 2
    logic [HB-1:0]              frac1;
    logic [HB:0]                inv1;
    logic [SF_W+CH_W-1:0]       sfq_full, sft_full;
    logic [SF_W-1:0]            sfq_next, sfq_reg, sft_next, sft_reg;
    logic [PROD_W-1:0]          pp_next, pp_reg;
    logic [2:0]                 sec2_reg;
    logic [CH_W-1:0]            v2_reg;
    logic                       grey2_reg;

    // stage 3
    logic [SF_W-1:0]            full255;
    logic [SF_W+CH_W-1:0]       nq, nt;
    logic [PROD_W-1:0]          xq_next, xq_reg, xt_next, xt_reg, xp3_reg;
    logic [2:0]                 sec3_reg;
    logic [CH_W-1:0]            v3_reg;
    logic                       grey3_reg;

    // stage 4
    logic [CH_W-1:0]            q4_reg, t4_reg, p4_reg;
    logic [2:0]                 sec4_reg;
    logic [CH_W-1:0]            v4_reg;
    logic                       grey4_reg;

    // stage 5
    logic [CH_W-1:0]            r_next, g_next, b_next;
    logic [CH_W-1:0]            r_reg, g_reg, b_reg;
    logic                       grey5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= GRAY_THR_RST;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // handshake: a stage advances when empty or when the next one advances
    assign vld_in = {vld_reg, s_tvalid};
    always_comb begin
        en[NUM_STAGES] = !vld_reg[NUM_STAGES] || m_tready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end
    assign s_tready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_in[k-1];
                end
            end
        end
    end

    // stage 1: unpack, hue * 6, grey decision
    assign hue_in     = s_tdata[HB-1:0];
    assign sat_in     = s_tdata[HB+CH_W-1:HB];
    assign val_in     = s_tdata[HB+2*CH_W-1:HB+CH_W];
    assign h6_next    = ({3'b000, hue_in} << 2) + ({3'b000, hue_in} << 1);
    assign grey1_next = sat_in < thr_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            h6_reg    <= h6_next;
            s1_reg    <= sat_in;
            v1_reg    <= val_in;
            grey1_reg <= grey1_next;
        end
    end

    // stage 2: S*F, S*(D-F), V*(255-S)
    assign frac1    = h6_reg[HB-1:0];
    assign inv1     = {1'b1, {HB{1'b0}}} - {1'b0, frac1};
    assign sfq_full = {{(SF_W){1'b0}}, s1_reg} * {{(2*CH_W){1'b0}}, frac1};
    assign sft_full = {{(SF_W){1'b0}}, s1_reg} * {{(2*CH_W-1){1'b0}}, inv1};
    assign sfq_next = sfq_full[SF_W-1:0];
    assign sft_next = sft_full[SF_W-1:0];
    assign pp_next  = {{CH_W{1'b0}}, v1_reg} * {{CH_W{1'b0}}, CH_MAX - s1_reg};

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            sfq_reg   <= sfq_next;
            sft_reg   <= sft_next;
            pp_reg    <= pp_next;
            sec2_reg  <= h6_reg[H6_W-1:HB];
            v2_reg    <= v1_reg;
            grey2_reg <= grey1_reg;
        end
    end

    // stage 3: V*(255D - S*F) and V*(255D - S*(D-F)), drop the D factor
    assign full255 = {CH_MAX, {HB{1'b0}}};
    assign nq      = {{CH_W{1'b0}}, full255 - sfq_reg} * {{SF_W{1'b0}}, v2_reg};
    assign nt      = {{CH_W{1'b0}}, full255 - sft_reg} * {{SF_W{1'b0}}, v2_reg};
    assign xq_next = nq[HB+PROD_W-1:HB];
    assign xt_next = nt[HB+PROD_W-1:HB];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            xq_reg    <= xq_next;
            xt_reg    <= xt_next;
            xp3_reg   <= pp_reg;
            sec3_reg  <= sec2_reg;
            v3_reg    <= v2_reg;
            grey3_reg <= grey2_reg;
        end
    end

    // stage 4: divide by 255
    hsv_div255 u_div_q (.aclk(aclk), .en(en[4]), .x(xq_reg),  .q_reg(q4_reg));
    hsv_div255 u_div_t (.aclk(aclk), .en(en[4]), .x(xt_reg),  .q_reg(t4_reg));
    hsv_div255 u_div_p (.aclk(aclk), .en(en[4]), .x(xp3_reg), .q_reg(p4_reg));

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sec4_reg  <= sec3_reg;
            v4_reg    <= v3_reg;
            grey4_reg <= grey3_reg;
        end
    end

    // stage 5: sector select
    always_comb begin
        if (grey4_reg) begin
            r_next = v4_reg;
            g_next = v4_reg;
            b_next = v4_reg;
        end else begin
            unique case (sector_t'(sec4_reg))
                SEC_RED: begin
                    r_next = v4_reg; g_next = t4_reg; b_next = p4_reg;
                end
                SEC_YELLOW: begin
                    r_next = q4_reg; g_next = v4_reg; b_next = p4_reg;
                end
                SEC_GREEN: begin
                    r_next = p4_reg; g_next = v4_reg; b_next = t4_reg;
                end
                SEC_CYAN: begin
                    r_next = p4_reg; g_next = q4_reg; b_next = v4_reg;
                end
                SEC_BLUE: begin
                    r_next = t4_reg; g_next = p4_reg; b_next = v4_reg;
                end
                default: begin
                    r_next = v4_reg; g_next = p4_reg; b_next = q4_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            r_reg     <= r_next;
            g_reg     <= g_next;
            b_reg     <= b_next;
            grey5_reg <= grey4_reg;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES];
    assign m_tdata  = {b_reg, g_reg, r_reg};

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_RST(a_stall_full, aclk, aresetn, !s_tready |-> (&vld_reg), "input stalled with a bubble")
    `ASSERT_RST(a_terms_bound, aclk, aresetn,
        vld_reg[4] |-> (q4_reg <= v4_reg && t4_reg <= v4_reg && p4_reg <= v4_reg),
        "term exceeds value")
    `ASSERT_RST(a_grey_out, aclk, aresetn,
        (m_tvalid && grey5_reg) |-> (r_reg == g_reg && g_reg == b_reg), "grey pixel not grey")
endmodule
`default_nettype wire
